[hw/rtl/pts_pkg.sv]
// package for the priority task scheduler: operation codes, slot status codes,
// default sizes and shared types. no dependencies.
package pts_pkg;

    localparam int TASK_SLOTS_DEF = 16;
    localparam int IDLE_PRIO_DEF  = 101;

    localparam logic [2:0] OP_CREATE    = 3'd0;
    localparam logic [2:0] OP_RUN       = 3'd1;
    localparam logic [2:0] OP_DELAY     = 3'd2;
    localparam logic [2:0] OP_TICK      = 3'd3;
    localparam logic [2:0] OP_ISR_ENTER = 3'd4;
    localparam logic [2:0] OP_ISR_EXIT  = 3'd5;

    localparam logic [1:0] ST_UNUSED  = 2'd0;
    localparam logic [1:0] ST_READY   = 2'd1;
    localparam logic [1:0] ST_DELAYED = 2'd2;

    // command broadcast to every cell in a pass
    typedef struct packed {
        logic tick;   // decrement delayed counts
        logic load;   // write new task into the addressed cell
        logic park;   // delay the addressed cell
        logic shift;  // rotate cells one place toward the scan head
    } t_cell_cmd;

endpackage

[hw/rtl/pts_cell.sv]
// one task slot cell: holds priority, status and delay count, hands them to its
// neighbor on each rotate cycle. depends on pts_pkg.
module pts_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pts_pkg::t_cell_cmd   i_cmd,
    input  logic                 i_sel,
    input  logic [1:0]           i_rst_status,
    input  logic [7:0]           i_rst_prio,
    input  logic [7:0]           i_new_prio,
    input  logic [15:0]          i_new_delay,
    input  logic [7:0]           i_prev_prio,
    input  logic [1:0]           i_prev_status,
    input  logic [15:0]          i_prev_delay,
    output logic [7:0]           o_prio,
    output logic [1:0]           o_status,
    output logic [15:0]          o_delay
);
    import pts_pkg::*;

    logic [7:0]  r_prio;
    logic [1:0]  r_status;
    logic [15:0] r_delay;
    logic [15:0] n_dec;

    assign n_dec = (r_delay != 16'd0) ? r_delay - 16'd1 : r_delay;

    // slot state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prio   <= i_rst_prio;
            r_status <= i_rst_status;
            r_delay  <= 16'd0;
        end else if (i_cmd.shift) begin
            r_prio   <= i_prev_prio;
            r_status <= i_prev_status;
            r_delay  <= i_prev_delay;
        end else if (i_cmd.load && i_sel) begin
            r_prio   <= i_new_prio;
            r_status <= ST_READY;
            r_delay  <= 16'd0;
        end else if (i_cmd.park && i_sel) begin
            r_delay <= i_new_delay;
            if (i_new_delay != 16'd0) begin
                r_status <= ST_DELAYED;
            end
        end else if (i_cmd.tick && r_status == ST_DELAYED) begin
            r_delay <= n_dec;
            if (n_dec == 16'd0) begin
                r_status <= ST_READY;
            end
        end
    end

    assign o_prio   = r_prio;
    assign o_status = r_status;
    assign o_delay  = r_delay;

endmodule

[hw/rtl/priority_task_scheduler_with_delays.sv]
// priority task scheduler top level: ring of slot cells plus a sequencer that
// rotates the ring once to find the most urgent ready slot. depends on pts_pkg, pts_cell.
// a transaction that needs a search pass goes through the command cycle, the rotate cycles of a
// full pass, the end of pass and the registered output; others skip the rotate cycles.
// the next transaction is taken only after the result is registered, so no new transaction
// is taken before the last one is through; reset is synchronous active low.
module priority_task_scheduler_with_delays #(
    parameter int TASK_SLOTS = pts_pkg::TASK_SLOTS_DEF,
    parameter int IDLE_PRIO  = pts_pkg::IDLE_PRIO_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] operation, [10:3] task_priority_in, [26:11] delay_ticks, [31:27] zero
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] running_task, [4] running_valid, [5] switched, [21:6] switch_total,
    // [37:22] tick_total, [41:38] new_slot, [42] table_full, [47:43] zero
    output logic [47:0] m_axis_tdata
);
    import pts_pkg::*;

    localparam int SW = $clog2(TASK_SLOTS);
    localparam int UW = $clog2(TASK_SLOTS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]    r_state;
    logic [2:0]    r_op;
    logic [7:0]    r_prio_in;
    logic [15:0]   r_ticks;
    logic [SW-1:0] r_rot;      // how many places the ring has rotated
    logic [SW:0]   r_cnt;
    logic [8:0]    r_best_prio;
    logic [SW-1:0] r_best;
    logic [UW-1:0] r_used;
    logic          r_started;
    logic [7:0]    r_nest;
    logic [SW-1:0] r_cur;
    logic [15:0]   r_sw_cnt;
    logic [15:0]   r_tick_cnt;
    logic          r_skip;     // command cycle only, no search pass
    logic [SW-1:0] r_made;
    logic          r_full;
    logic          r_first;
    logic          r_ovalid;
    logic [47:0]   r_odata;

    t_cell_cmd     w_cmd;
    logic [SW-1:0] w_sel_idx;
    logic [7:0]    w_prio   [TASK_SLOTS];
    logic [1:0]    w_status [TASK_SLOTS];
    logic [15:0]   w_delay  [TASK_SLOTS];
    logic [SW-1:0] w_head_slot;
    logic          w_acc;
    logic [SW-1:0] w_win;
    logic          w_win_sw;
    logic          w_found;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_acc = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    // cell commands for this cycle
    always_comb begin
        w_cmd = '0;
        w_sel_idx = r_made;
        if (r_state == S_SCAN && r_cnt == '0) begin
            w_cmd.load = (r_op == OP_CREATE) && !r_full;
            w_cmd.park = (r_op == OP_DELAY) && (r_cur != '0);
            w_cmd.tick = (r_op == OP_TICK);
            w_sel_idx  = (r_op == OP_CREATE) ? r_made : r_cur;
        end else if (r_state == S_SCAN && r_cnt != (SW+1)'(TASK_SLOTS + 1)) begin
            w_cmd.shift = 1'b1;
        end
    end

    // ring of slot cells, cell 0 is the scan head
    for (genvar g = 0; g < TASK_SLOTS; g++) begin : g_cell
        pts_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_sel        (w_sel_idx == SW'(g)),
            .i_rst_status ((g == 0) ? ST_READY : ST_UNUSED),
            .i_rst_prio   ((g == 0) ? 8'(IDLE_PRIO) : 8'd0),
            .i_new_prio   (r_prio_in),
            .i_new_delay  (r_ticks),
            .i_prev_prio  (w_prio[(g + 1) % TASK_SLOTS]),
            .i_prev_status(w_status[(g + 1) % TASK_SLOTS]),
            .i_prev_delay (w_delay[(g + 1) % TASK_SLOTS]),
            .o_prio       (w_prio[g]),
            .o_status     (w_status[g]),
            .o_delay      (w_delay[g])
        );
    end

    // slot number currently at the head; a full rotation restores the order
    assign w_head_slot = r_rot;
    assign w_found = (r_best_prio != 9'd256);
    assign w_win = w_found ? r_best : r_cur;
    assign w_win_sw = w_found && (w_win != r_cur);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_used     <= UW'(1);
            r_started  <= 1'b0;
            r_nest     <= 8'd0;
            r_cur      <= '0;
            r_sw_cnt   <= 16'd0;
            r_tick_cnt <= 16'd0;
            r_ovalid   <= 1'b0;
            r_cnt      <= '0;
            r_rot      <= '0;
        end else begin
            if (r_ovalid && m_axis_tready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_op        <= s_axis_tdata[2:0];
                        r_prio_in   <= s_axis_tdata[10:3];
                        r_ticks     <= s_axis_tdata[26:11];
                        r_made      <= '0;
                        r_full      <= 1'b0;
                        r_first     <= 1'b0;
                        r_cnt       <= '0;
                        r_rot       <= '0;
                        r_best_prio <= 9'd256;
                        r_best      <= '0;
                        r_state     <= S_SCAN;
                        case (s_axis_tdata[2:0])
                            OP_CREATE: begin
                                if (r_used >= UW'(TASK_SLOTS)) begin
                                    r_full <= 1'b1;
                                end else begin
                                    r_made <= SW'(r_used);
                                    r_used <= r_used + UW'(1);
                                end
                            end
                            OP_RUN: begin
                                if (!r_started) begin
                                    r_started <= 1'b1;
                                    r_cur     <= '0;
                                    r_first   <= 1'b1;
                                end
                            end
                            OP_TICK: r_tick_cnt <= r_tick_cnt + 16'd1;
                            OP_ISR_ENTER: begin
                                if (r_nest != 8'd255) r_nest <= r_nest + 8'd1;
                            end
                            OP_ISR_EXIT: begin
                                if (r_nest != 8'd0) r_nest <= r_nest - 8'd1;
                            end
                            default: ;
                        endcase
                        // does this transaction need a search pass
                        r_skip <= !((s_axis_tdata[2:0] == OP_CREATE && r_started
                                      && r_used < UW'(TASK_SLOTS))
                                    || s_axis_tdata[2:0] == OP_RUN
                                    || (s_axis_tdata[2:0] == OP_DELAY && r_started)
                                    || (s_axis_tdata[2:0] == OP_ISR_EXIT && r_started
                                        && r_nest == 8'd1));
                    end
                end
                S_SCAN: begin
                    if (r_cnt == (SW+1)'(TASK_SLOTS + 1)) begin
                        r_state <= S_OUT;
                    end else if (r_cnt == '0 && r_skip) begin
                        // cell command issued, no search needed
                        r_cnt <= (SW+1)'(TASK_SLOTS + 1);
                    end else begin
                        // compare the head cell, then rotate
                        if (r_cnt != '0 && w_status[0] == ST_READY
                                && {1'b0, w_prio[0]} < r_best_prio) begin
                            r_best_prio <= {1'b0, w_prio[0]};
                            r_best      <= w_head_slot;
                        end
                        if (r_cnt != '0) begin
                            r_rot <= (r_rot == SW'(TASK_SLOTS - 1)) ? '0 : r_rot + SW'(1);
                        end
                        r_cnt <= r_cnt + (SW+1)'(1);
                    end
                end
                S_OUT: begin
                    // hold here while the previous result still waits
                    if (!r_ovalid || m_axis_tready) begin
                        r_state <= S_IDLE;
                        r_ovalid <= 1'b1;
                        if (w_win_sw || r_first) begin
                            r_sw_cnt <= r_sw_cnt + 16'd1;
                        end
                        r_cur <= w_win;
                        r_odata <= {5'd0, r_full, 4'(r_made), r_tick_cnt,
                                    (w_win_sw || r_first) ? r_sw_cnt + 16'd1 : r_sw_cnt,
                                    (w_win_sw || r_first), r_started,
                                    r_started ? 4'(w_win) : 4'd0};
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    // result holds steady while the receiver stalls
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !m_axis_tready) |=> (r_ovalid && $stable(r_odata)))
        else $error("result changed while stalled");
    // scan head returns to slot order at end of pass
    a_ring_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (r_rot == '0)) else $error("ring not home");
    // idle slot is always ready
    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (w_status[0] == ST_READY)) else $error("idle not ready");
`endif

endmodule

[tb/tb_top.sv]
// self-checking testbench for the priority task scheduler: drives operation
// transactions, predicts each result and compares it. depends on pts_pkg and the rtl.
module tb_top;
    import pts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = TASK_SLOTS_DEF;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [15:0] ticks;
        logic [7:0]  prio;
        logic [2:0]  op;
    } t_cmd;

    typedef struct packed {
        logic        full;
        logic [3:0]  slot_made;
        logic [15:0] ticks_seen;
        logic [15:0] switches;
        logic        sw;
        logic        valid;
        logic [3:0]  running;
    } t_status;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;

    priority_task_scheduler_with_delays dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // shadow of the scheduler state
    logic [7:0]  sh_prio [SLOTS];
    logic [1:0]  sh_stat [SLOTS];
    logic [15:0] sh_dly  [SLOTS];
    int          sh_used;
    bit          sh_started;
    int          sh_nest;
    int          sh_cur;
    logic [15:0] sh_switches;
    logic [15:0] sh_ticks;

    t_cmd    pending_cmds[$];
    t_status expected_status[$];
    int      fail_count = 0;
    bit      quiet_mode = 1'b0;
    bit      hold_rx = 1'b0;
    int      tx_gap = 0;
    int      rx_gap = 0;
    int      idle_cycles = 0;

    function automatic void shadow_reset();
        for (int s = 0; s < SLOTS; s++) begin
            sh_prio[s] = '0;
            sh_stat[s] = ST_UNUSED;
            sh_dly[s] = '0;
        end
        sh_prio[0] = 8'(IDLE_PRIO_DEF);
        sh_stat[0] = ST_READY;
        sh_used = 1;
        sh_started = 1'b0;
        sh_nest = 0;
        sh_cur = 0;
        sh_switches = '0;
        sh_ticks = '0;
    endfunction

    // pick most urgent ready slot, returns 1 on a task change
    function automatic bit pick_next();
        int best;
        int best_prio;
        best = 0;
        best_prio = 256;
        for (int s = 0; s < SLOTS; s++) begin
            if (sh_stat[s] == ST_READY && int'(sh_prio[s]) < best_prio) begin
                best_prio = sh_prio[s];
                best = s;
            end
        end
        if (best_prio == 256 || best == sh_cur) return 1'b0;
        sh_cur = best;
        sh_switches++;
        return 1'b1;
    endfunction

    function automatic t_status schedule_step(t_cmd c);
        t_status r;
        bit sw;
        int made;
        bit full;
        sw = 1'b0;
        made = 0;
        full = 1'b0;
        case (c.op)
            OP_CREATE: begin
                if (sh_used >= SLOTS) begin
                    full = 1'b1;
                end else begin
                    made = sh_used;
                    sh_prio[made] = c.prio;
                    sh_stat[made] = ST_READY;
                    sh_dly[made] = '0;
                    sh_used++;
                    if (sh_started) sw = pick_next();
                end
            end
            OP_RUN: begin
                if (!sh_started) begin
                    sh_started = 1'b1;
                    sh_cur = 0;
                    sw = pick_next();
                    // first pick always counts as a switch
                    if (!sw) begin
                        sh_switches++;
                        sw = 1'b1;
                    end
                end else begin
                    sw = pick_next();
                end
            end
            OP_DELAY: begin
                if (sh_started) begin
                    if (sh_cur != 0) begin
                        sh_dly[sh_cur] = c.ticks;
                        if (c.ticks != 0) sh_stat[sh_cur] = ST_DELAYED;
                    end
                    sw = pick_next();
                end
            end
            OP_TICK: begin
                sh_ticks++;
                for (int s = 0; s < SLOTS; s++) begin
                    if (sh_stat[s] == ST_DELAYED) begin
                        if (sh_dly[s] != 0) sh_dly[s]--;
                        if (sh_dly[s] == 0) sh_stat[s] = ST_READY;
                    end
                end
            end
            OP_ISR_ENTER: begin
                if (sh_nest < 255) sh_nest++;
            end
            OP_ISR_EXIT: begin
                if (sh_nest != 0) begin
                    sh_nest--;
                    if (sh_nest == 0 && sh_started) sw = pick_next();
                end
            end
            default: ;
        endcase
        r.running = sh_started ? 4'(sh_cur) : 4'd0;
        r.valid = sh_started;
        r.sw = sw;
        r.switches = sh_switches;
        r.ticks_seen = sh_ticks;
        r.slot_made = 4'(made);
        r.full = full;
        return r;
    endfunction

    function automatic t_cmd make_cmd(logic [2:0] op, logic [7:0] prio, logic [15:0] ticks);
        t_cmd c;
        c.op = op;
        c.prio = prio;
        c.ticks = ticks;
        return c;
    endfunction

    // random operation mix biased toward delays and ticks
    function automatic t_cmd random_cmd();
        int pick;
        logic [15:0] t;
        pick = $urandom_range(0, 99);
        t = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
        if (pick < 8) return make_cmd(OP_CREATE, 8'($urandom), t);
        if (pick < 12) return make_cmd(OP_RUN, 8'($urandom), t);
        if (pick < 35) return make_cmd(OP_DELAY, 8'($urandom), t);
        if (pick < 75) return make_cmd(OP_TICK, 8'($urandom), t);
        if (pick < 86) return make_cmd(OP_ISR_ENTER, 8'($urandom), t);
        if (pick < 97) return make_cmd(OP_ISR_EXIT, 8'($urandom), t);
        return make_cmd(3'($urandom_range(6, 7)), 8'($urandom), 16'($urandom));
    endfunction

    // driver: predicts on acceptance, then offers the next command
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_status.push_back(schedule_step(t_cmd'(s_axis_tdata[26:0])));
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (tx_gap > 0) begin
                    tx_gap <= tx_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_cmds.size() > 0 && pending_cmds[0] === 'x) begin
                    // pause marker: wait for every result to come back
                    s_axis_tvalid <= 1'b0;
                    if (expected_status.size() == 0 && !(s_axis_tvalid && s_axis_tready)) begin
                        void'(pending_cmds.pop_front());
                    end
                end else if (pending_cmds.size() > 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {5'd0, pending_cmds.pop_front()};
                    if (!quiet_mode && $urandom_range(0, 5) == 0) begin
                        tx_gap <= $urandom_range(1, 11);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: ready with random stalls, compare each result
    always @(posedge i_clk) begin
        t_status got;
        t_status want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_status'(m_axis_tdata[42:0]);
                if (expected_status.size() == 0) begin
                    $error("unexpected result transaction %h", m_axis_tdata);
                    fail_count++;
                end else begin
                    want = expected_status.pop_front();
                    if (got.running !== want.running) begin
                        $error("running_task exp %0d got %0d", want.running, got.running);
                        fail_count++;
                    end
                    if (got.valid !== want.valid) begin
                        $error("running_valid exp %0d got %0d", want.valid, got.valid);
                        fail_count++;
                    end
                    if (got.sw !== want.sw) begin
                        $error("switched exp %0d got %0d", want.sw, got.sw);
                        fail_count++;
                    end
                    if (got.switches !== want.switches) begin
                        $error("switch_total exp %0d got %0d", want.switches, got.switches);
                        fail_count++;
                    end
                    if (got.ticks_seen !== want.ticks_seen) begin
                        $error("tick_total exp %0d got %0d", want.ticks_seen, got.ticks_seen);
                        fail_count++;
                    end
                    if (got.slot_made !== want.slot_made) begin
                        $error("new_slot exp %0d got %0d", want.slot_made, got.slot_made);
                        fail_count++;
                    end
                    if (got.full !== want.full) begin
                        $error("table_full exp %0d got %0d", want.full, got.full);
                        fail_count++;
                    end
                end
            end
            if (hold_rx) begin
                m_axis_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap <= rx_gap - 1;
                m_axis_tready <= 1'b0;
            end else if (!quiet_mode && $urandom_range(0, 6) == 0) begin
                rx_gap <= $urandom_range(0, 10);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        shadow_reset();
        // directed: behavior before run, then run and the special cases
        pending_cmds.push_back(make_cmd(OP_DELAY, 8'hff, 16'hffff));
        pending_cmds.push_back(make_cmd(OP_ISR_EXIT, 8'h00, 16'h0000));
        pending_cmds.push_back(make_cmd(OP_ISR_ENTER, 8'h00, 16'h0000));
        pending_cmds.push_back(make_cmd(OP_ISR_EXIT, 8'h00, 16'h0000));
        pending_cmds.push_back(make_cmd(OP_CREATE, 8'd0, 16'd0));
        pending_cmds.push_back(make_cmd(OP_CREATE, 8'd255, 16'd0));
        pending_cmds.push_back(make_cmd(OP_RUN, 8'd0, 16'd0));
        pending_cmds.push_back(make_cmd(OP_RUN, 8'd0, 16'd0));
        pending_cmds.push_back(make_cmd(OP_DELAY, 8'd0, 16'd0));
        pending_cmds.push_back(make_cmd(OP_DELAY, 8'd0, 16'd2));
        pending_cmds.push_back(make_cmd(OP_DELAY, 8'd0, 16'd5));
        pending_cmds.push_back(make_cmd(OP_TICK, 8'd0, 16'd0));
        pending_cmds.push_back(make_cmd(OP_TICK, 8'd0, 16'd0));
        pending_cmds.push_back(make_cmd(OP_ISR_ENTER, 8'd0, 16'd0));
        pending_cmds.push_back(make_cmd(OP_ISR_EXIT, 8'd0, 16'd0));
        pending_cmds.push_back(make_cmd(3'd6, 8'haa, 16'h5555));
        pending_cmds.push_back(make_cmd(3'd7, 8'h55, 16'haaaa));
        for (int k = 0; k < 15; k++) pending_cmds.push_back(make_cmd(OP_CREATE, 8'($urandom), '0));
        // nesting saturation then unwind
        for (int k = 0; k < 258; k++) pending_cmds.push_back(make_cmd(OP_ISR_ENTER, '0, '0));
        for (int k = 0; k < 256; k++) pending_cmds.push_back(make_cmd(OP_ISR_EXIT, '0, '0));
        pending_cmds.push_back('x);
        for (int k = 0; k < 1000; k++) pending_cmds.push_back(random_cmd());

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // long receiver hold-off while the sender keeps offering
        repeat (20) @(posedge i_clk);
        hold_rx <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_rx <= 1'b0;

        // tail without idling
        while (pending_cmds.size() >= 100) @(posedge i_clk);
        @(posedge i_clk);
        quiet_mode <= 1'b1;
        while (pending_cmds.size() != 0 || s_axis_tvalid || expected_status.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

[priority_task_scheduler_with_delays.f]
hw/rtl/pts_pkg.sv
hw/rtl/pts_cell.sv
hw/rtl/priority_task_scheduler_with_delays.sv
tb/tb_top.sv
